FILE: rtl/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// Types and constants shared by the automaton pattern matcher modules.
// ----------------------------------------------------------------------------
package apm_pkg;

	// Pattern storage provided by the configuration registers.
	localparam int PATTERN_WORDS      = 4;
	localparam int BYTES_PER_WORD     = 8;
	localparam int CFG_PATTERN_BYTES  = PATTERN_WORDS * BYTES_PER_WORD;
	localparam int CFG_INDEX_WIDTH    = 3;
	localparam int CFG_DATA_WIDTH     = 64;
	localparam int PATTERN_LEN_WIDTH  = 6;
	localparam int INDEX_WIDTH        = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PATTERN_WORD0  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PATTERN_WORD1  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PATTERN_WORD2  = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PATTERN_WORD3  = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       first_of_text;
	} text_item_t;

	typedef struct packed {
		logic                         match_found;
		logic [INDEX_WIDTH-1:0]       match_start;
		logic [PATTERN_LEN_WIDTH-1:0] prefix_matched;
	} result_item_t;

	// Per-byte bookkeeping that travels from the front part to the back part.
	typedef struct packed {
		logic                   restart;
		logic [INDEX_WIDTH-1:0] idx;
	} job_info_t;

endpackage

FILE: rtl/apm_front.sv
// ----------------------------------------------------------------------------
// apm_front
// Accepts text bytes, keeps the recent-byte window and the byte index, and
// compares every pattern prefix against the window in one registered stage.
// ----------------------------------------------------------------------------
module apm_front
	import apm_pkg::*;
#(
	parameter int MAX_PATTERN = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_stall,
	input  text_item_t             text_item,
	input  logic [7:0]             pattern_bytes [MAX_PATTERN],
	input  logic                   queue_full,
	output logic                   push,
	output logic [MAX_PATTERN-1:0] fits,
	output job_info_t              job
);

	logic [7:0]             recent_q [MAX_PATTERN];
	logic [INDEX_WIDTH-1:0] index_q;
	logic                   valid_s1;
	job_info_t              job_s1;
	logic                   accept;
	logic [INDEX_WIDTH-1:0] idx_now;

	assign text_stall = valid_s1 && queue_full;
	assign accept     = text_valid && !text_stall;
	assign push       = valid_s1 && !queue_full;
	assign job        = job_s1;
	assign idx_now    = text_item.first_of_text ? '0 : index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			index_q  <= '0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				recent_q[i] <= '0;
			end
		end else if (accept) begin
			valid_s1    <= 1'b1;
			recent_q[0] <= text_item.text_byte;
			for (int i = 1; i < MAX_PATTERN; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
			// The index saturates at its top value.
			index_q <= (&idx_now) ? idx_now : idx_now + 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.restart <= text_item.first_of_text;
			job_s1.idx     <= idx_now;
		end
	end

	// Bit k-1 is set when pattern bytes 0..k-1 equal the newest k window bytes.
	// The window already holds the byte of the item in stage one, since no
	// later byte enters until that item has moved on.
	always_comb begin
		logic f;
		for (int k = 1; k <= MAX_PATTERN; k++) begin
			f = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (j < k) begin
					f = f && (pattern_bytes[j] == recent_q[k-1-j]);
				end
			end
			fits[k-1] = f;
		end
	end

endmodule

FILE: rtl/apm_queue.sv
// ----------------------------------------------------------------------------
// apm_queue
// Two-entry queue between the front and back parts of the matcher.
// ----------------------------------------------------------------------------
module apm_queue
	import apm_pkg::*;
#(
	parameter int WIDTH = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] data_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full       = count_q[1];
	assign head_valid = count_q != 2'd0;
	assign head_data  = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/apm_back.sv
// ----------------------------------------------------------------------------
// apm_back
// Advances the automaton state: picks the longest fitting prefix allowed by
// the previous state and registers the result transaction.
// ----------------------------------------------------------------------------
module apm_back
	import apm_pkg::*;
#(
	parameter int MAX_PATTERN = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  logic [MAX_PATTERN-1:0] head_fits,
	input  job_info_t              head_job,
	input  logic [$clog2(MAX_PATTERN+1)-1:0] len,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_item_t           result_item
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic              result_valid_q;
	result_item_t      result_item_q;
	logic [LW-1:0]     matched_q;
	logic [LW-1:0]     prev;
	logic [LW:0]       limit;
	logic [LW-1:0]     next;
	logic              load;
	logic              found;

	assign load         = !result_valid_q || !result_stall;
	assign pop          = head_valid && load;
	assign result_valid = result_valid_q;
	assign result_item  = result_item_q;

	always_comb begin
		prev = head_job.restart ? '0 : matched_q;
		// The pattern may have shrunk since the state was stored.
		if (prev > len) begin
			prev = len;
		end
		limit = {1'b0, prev} + 1'b1;
		if (limit > {1'b0, len}) begin
			limit = {1'b0, len};
		end
		next = '0;
		for (int k = 1; k <= MAX_PATTERN; k++) begin
			if (head_fits[k-1] && ((LW+1)'(k) <= limit)) begin
				next = LW'(k);
			end
		end
		found = next == len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			matched_q      <= '0;
		end else if (pop) begin
			result_valid_q <= 1'b1;
			matched_q      <= next;
		end else if (load) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_item_q.match_found    <= found;
			result_item_q.match_start    <= found
				? head_job.idx - INDEX_WIDTH'(len) + 1'b1 : '0;
			result_item_q.prefix_matched <= PATTERN_LEN_WIDTH'(next);
		end
	end

endmodule

FILE: rtl/automaton_pattern_matcher_unit.sv
// ----------------------------------------------------------------------------
// automaton_pattern_matcher_unit
// Streaming byte-pattern matcher. Text bytes enter on the text channel
// (text_valid, text_stall, text_item); each produces exactly one result
// transaction on the result channel (result_valid, result_stall, result_item)
// with the automaton state, a match flag and the start index of the match.
// Overlapping matches are all reported. first_of_text restarts the index and
// the automaton at that byte. The user must write the pattern and its length
// through the configuration port only while no transaction is in flight; the
// block does not enforce this. A byte passes the front stage, the queue and the
// result register. Throughput is one byte per cycle while result_stall is low,
// set by the prefix compare in the front part and the state update in the back
// part. A two-entry queue separates the parts; a held result_stall fills it and
// text_stall rises with its full flag. Reset clears the automaton, the byte
// index, the text window and the pattern (length 1, bytes zero).
// ----------------------------------------------------------------------------
module automaton_pattern_matcher_unit
	import apm_pkg::*;
#(
	parameter int MAX_PATTERN = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       text_valid,
	output logic                       text_stall,
	input  text_item_t                 text_item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output result_item_t               result_item,
	input  logic                       cfg_write_en,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int QW = MAX_PATTERN + $bits(job_info_t);

	logic [PATTERN_LEN_WIDTH-1:0] pattern_length_q;
	logic [CFG_DATA_WIDTH-1:0]    pattern_words_q [PATTERN_WORDS];
	logic [7:0]                   pattern_bytes [MAX_PATTERN];
	logic [PATTERN_LEN_WIDTH:0]   len_wide;
	logic [LW-1:0]                len;

	logic                   push;
	logic                   pop;
	logic                   queue_full;
	logic                   head_valid;
	logic [MAX_PATTERN-1:0] fits;
	job_info_t              job;
	logic [QW-1:0]          head_data;
	logic [MAX_PATTERN-1:0] head_fits;
	job_info_t              head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PATTERN_LEN_WIDTH'(1);
			for (int w = 0; w < PATTERN_WORDS; w++) begin
				pattern_words_q[w] <= '0;
			end
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[PATTERN_LEN_WIDTH-1:0];
				CFG_PATTERN_WORD0:  pattern_words_q[0] <= cfg_data;
				CFG_PATTERN_WORD1:  pattern_words_q[1] <= cfg_data;
				CFG_PATTERN_WORD2:  pattern_words_q[2] <= cfg_data;
				CFG_PATTERN_WORD3:  pattern_words_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Positions past the configured storage compare against zero.
	for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_pattern
		if (p < CFG_PATTERN_BYTES) begin : g_stored
			localparam int WORD = p / BYTES_PER_WORD;
			localparam int LSB  = (p % BYTES_PER_WORD) * 8;
			assign pattern_bytes[p] = pattern_words_q[WORD][LSB +: 8];
		end else begin : g_zero
			assign pattern_bytes[p] = 8'd0;
		end
	end

	// A length of zero acts as one, and lengths above the limit are clamped.
	always_comb begin
		len_wide = {1'b0, pattern_length_q};
		if (len_wide == '0) begin
			len_wide = (PATTERN_LEN_WIDTH+1)'(1);
		end else if (len_wide > (PATTERN_LEN_WIDTH+1)'(MAX_PATTERN)) begin
			len_wide = (PATTERN_LEN_WIDTH+1)'(MAX_PATTERN);
		end
		len = LW'(len_wide);
	end

	apm_front #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_valid    (text_valid),
		.text_stall    (text_stall),
		.text_item     (text_item),
		.pattern_bytes (pattern_bytes),
		.queue_full    (queue_full),
		.push          (push),
		.fits          (fits),
		.job           (job)
	);

	apm_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({fits, job}),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_fits = head_data[QW-1 -: MAX_PATTERN];
	assign head_job  = head_data[$bits(job_info_t)-1:0];

	apm_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_fits    (head_fits),
		.head_job     (head_job),
		.len          (len),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

`ifndef ASSERT_OFF
	// A reported match always leaves the automaton in its full-length state.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.match_found |->
			(PATTERN_LEN_WIDTH+1)'(result_item.prefix_matched) == len_wide)
		else $error("match reported without full-length state");

	// Without a match the start index reads as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.match_found |-> result_item.match_start == '0)
		else $error("match start nonzero without a match");

	// The automaton state never exceeds the pattern length in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (PATTERN_LEN_WIDTH+1)'(result_item.prefix_matched) <= len_wide)
		else $error("automaton state beyond pattern length");

	// The input side is held off only while the queue has no room.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> queue_full)
		else $error("input stalled while the queue had room");
`endif

endmodule
